/* src/tcgr_pkg.sv */
package tcgr_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_FRAME_BASE       = 3'd0;
   localparam logic [2:0] CSR_SCREEN_WIDTH     = 3'd1;
   localparam logic [2:0] CSR_FOREGROUND_COLOR = 3'd2;
   localparam logic [2:0] CSR_BACKGROUND_COLOR = 3'd3;
   localparam logic [2:0] CSR_ROW_LIMIT        = 3'd4;

   localparam logic [31:0] FRAME_BASE_RESET       = 32'd0;
   localparam logic [12:0] SCREEN_WIDTH_RESET     = 13'd1024;
   localparam logic [15:0] FOREGROUND_COLOR_RESET = 16'hffff;
   localparam logic [15:0] BACKGROUND_COLOR_RESET = 16'h0000;
   localparam logic [7:0]  ROW_LIMIT_RESET        = 8'd45;

   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [7:0]  CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0]  CHAR_QUERY   = 8'h3f;
   localparam logic [11:0] COLUMN_MAX   = 12'hfff;
   localparam logic [7:0]  ROW_MAX      = 8'hff;
   localparam int unsigned FONT_ADDRESS_SPAN = 4096;

   localparam logic OP_DRAW       = 1'b0;
   localparam logic OP_FONT_WRITE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  char_code;
      logic [11:0] font_address;
      logic [7:0]  font_data;
   } req_word_type;

   typedef struct packed {
      logic [31:0] pixel_address;
      logic [15:0] pixel_zero;
      logic [15:0] pixel_one;
      logic [15:0] pixel_two;
      logic [15:0] pixel_three;
      logic [15:0] pixel_four;
      logic [15:0] pixel_five;
      logic [15:0] pixel_six;
      logic [15:0] pixel_seven;
      logic        final_row;
   } rsp_word_type;

   typedef enum logic [2:0] {
      CLASS_FONT_WRITE,
      CLASS_DROP,
      CLASS_NEWLINE,
      CLASS_TAB,
      CLASS_DRAW
   } word_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_BASE,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic mult;
      logic base;
      logic run;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_draw;
      logic run_done;
   } dp_status_type;

endpackage

/* src/text_console_glyph_renderer.sv */
// channel  direction  ports                                 word
// req      in         req_valid, req_stall, req_data        font write or character code
// rsp      out        rsp_valid, rsp_stall, rsp_data        one glyph row of eight pixels
// csr      in         csr_write, csr_index, csr_data        configuration register write
//
// a drawn character goes from accept through line multiply, base address and one font read per glyph
// row, with rsp_stall able to hold the reads, then moves the last row out and returns to idle; other
// words are handled in the idle state itself
// reset (synchronous, active high) clears cursor and handshake state and loads configuration reset values;
// the font store is not cleared and must be loaded before drawing
// rsp_stall holds the read pipeline; the output register frees req while the last row waits
module text_console_glyph_renderer #(
   parameter int GLYPH_ROWS  = 16,
   parameter int GLYPH_COUNT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tcgr_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tcgr_pkg::rsp_word_type rsp_data,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import tcgr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tcgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcgr_datapath #(
      .GLYPH_ROWS  (GLYPH_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* src/tcgr_ctrl.sv */
module tcgr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcgr_pkg::dp_status_type status,
   output tcgr_pkg::ctrl_cmd_type  cmd
);
   import tcgr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.is_draw) state_in = ST_MULT;
         end
         ST_MULT: state_in = ST_BASE;
         ST_BASE: state_in = ST_RUN;
         ST_RUN: begin
            if (status.run_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_MULT: cmd.mult = 1'b1;
         ST_BASE: cmd.base = 1'b1;
         ST_RUN:  cmd.run  = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

/* src/tcgr_datapath.sv */
module tcgr_datapath #(
   parameter int GLYPH_ROWS  = 16,
   parameter int GLYPH_COUNT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcgr_pkg::req_word_type  req_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output tcgr_pkg::rsp_word_type  rsp_data,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  tcgr_pkg::ctrl_cmd_type  cmd,
   output tcgr_pkg::dp_status_type status
);
   import tcgr_pkg::*;

   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);
   localparam int GLYPH_W    = $clog2(GLYPH_COUNT);
   localparam int ROW_W      = $clog2(GLYPH_ROWS);
   localparam int LINE_W     = 8 + ROW_W;
   localparam int PROD_W     = LINE_W + 13;
   localparam int SUB_STEPS  = (FONT_ADDRESS_SPAN - 1) / FONT_DEPTH;
   localparam logic [13:0] DEPTH_L      = 14'(FONT_DEPTH);
   localparam logic [8:0]  GLYPH_L      = 9'(GLYPH_COUNT);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

   // configuration
   logic [31:0] frame_base_ff;
   logic [12:0] screen_width_ff;
   logic [15:0] fg_color_ff;
   logic [15:0] bg_color_ff;
   logic [7:0]  row_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= FRAME_BASE_RESET;
         screen_width_ff <= SCREEN_WIDTH_RESET;
         fg_color_ff     <= FOREGROUND_COLOR_RESET;
         bg_color_ff     <= BACKGROUND_COLOR_RESET;
         row_limit_ff    <= ROW_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_BASE:       frame_base_ff   <= csr_data;
            CSR_SCREEN_WIDTH:     screen_width_ff <= csr_data[12:0];
            CSR_FOREGROUND_COLOR: fg_color_ff     <= csr_data[15:0];
            CSR_BACKGROUND_COLOR: bg_color_ff     <= csr_data[15:0];
            CSR_ROW_LIMIT:        row_limit_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // word decode
   logic [11:0]    col_ff, col_in;
   logic [7:0]     row_ff, row_in;
   logic [7:0]     code_eff;
   word_class_type word_class;

   always_comb begin
      code_eff = req_data.char_code[7] ? CHAR_QUERY : req_data.char_code;
      priority if (req_data.operation == OP_FONT_WRITE) begin
         word_class = CLASS_FONT_WRITE;
      end else if (row_ff > row_limit_ff) begin
         word_class = CLASS_DROP;
      end else if (req_data.char_code[7] && !req_data.char_code[6]) begin
         word_class = CLASS_DROP;
      end else if (code_eff == CHAR_NEWLINE) begin
         word_class = CLASS_NEWLINE;
      end else if (code_eff == CHAR_TAB) begin
         word_class = CLASS_TAB;
      end else begin
         word_class = CLASS_DRAW;
      end
   end

   // font write address folded into the store depth
   logic [13:0] wr_fold;
   always_comb begin
      wr_fold = {2'b00, req_data.font_address};
      for (int i = 0; i < SUB_STEPS; i++) begin
         if (wr_fold >= DEPTH_L) wr_fold = wr_fold - DEPTH_L;
      end
   end

   // cursor
   logic [12:0] tab_sum;
   logic [11:0] tab_col;
   logic [7:0]  row_next;

   always_comb begin
      tab_sum  = {1'b0, col_ff | 12'h007} + 13'd1;
      tab_col  = tab_sum[12] ? COLUMN_MAX : tab_sum[11:0];
      row_next = (row_ff == ROW_MAX) ? row_ff : row_ff + 8'd1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (cmd.accept && word_class == CLASS_NEWLINE) begin
         col_in = '0;
         row_in = row_next;
      end else if (cmd.accept && word_class == CLASS_TAB) begin
         if ({1'b0, tab_col} > {3'b000, screen_width_ff[12:3]}) begin
            col_in = '0;
            row_in = row_next;
         end else begin
            col_in = tab_col;
         end
      end else if (cmd.base && col_ff != COLUMN_MAX) begin
         col_in = col_ff + 12'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // glyph setup: line index, then product, then first pixel address
   logic [GLYPH_W-1:0] glyph_ff;
   logic [LINE_W-1:0]  line_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [FONT_AW-1:0] glyph_base_ff;
   logic [31:0]        pix_addr_ff;
   logic [8:0]         glyph_fold;

   always_comb begin
      glyph_fold = {1'b0, code_eff};
      if (glyph_fold >= GLYPH_L) glyph_fold = glyph_fold - GLYPH_L;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         glyph_ff <= glyph_fold[GLYPH_W-1:0];
         line_ff  <= LINE_W'(row_ff * GLYPH_ROWS);
      end
      if (cmd.mult) begin
         prod_ff       <= PROD_W'(line_ff) * PROD_W'(screen_width_ff);
         glyph_base_ff <= FONT_AW'(glyph_ff * GLYPH_ROWS);
      end
   end

   // row issue and font read
   logic [7:0]         font_mem [FONT_DEPTH];
   logic [7:0]         mem_rdata_ff;
   logic [ROW_W-1:0]   rcnt_ff;
   logic               issuing_ff;
   logic               stage_valid_ff;
   logic               stage_last_ff;
   logic [31:0]        stage_addr_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;
   logic               adv;
   logic               rd_en;

   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign rd_en = cmd.run && adv && issuing_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && word_class == CLASS_FONT_WRITE) begin
         font_mem[wr_fold[FONT_AW-1:0]] <= req_data.font_data;
      end
      if (rd_en) begin
         mem_rdata_ff <= font_mem[glyph_base_ff + FONT_AW'(rcnt_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.base) begin
         pix_addr_ff <= frame_base_ff + 32'({prod_ff, 1'b0}) + {16'h0000, col_ff, 4'h0};
      end else if (rd_en) begin
         pix_addr_ff <= pix_addr_ff + {18'h00000, screen_width_ff, 1'b0};
      end
      if (rd_en) begin
         stage_addr_ff <= pix_addr_ff;
         stage_last_ff <= (rcnt_ff == LAST_ROW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcnt_ff        <= '0;
         issuing_ff     <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (cmd.base) begin
            rcnt_ff    <= '0;
            issuing_ff <= 1'b1;
         end else if (rd_en) begin
            rcnt_ff <= rcnt_ff + ROW_W'(1);
            if (rcnt_ff == LAST_ROW) issuing_ff <= 1'b0;
         end
         if (cmd.run && adv) stage_valid_ff <= issuing_ff;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && stage_valid_ff) begin
         rsp_data_ff.pixel_address <= stage_addr_ff;
         rsp_data_ff.pixel_zero    <= mem_rdata_ff[0] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_one     <= mem_rdata_ff[1] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_two     <= mem_rdata_ff[2] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_three   <= mem_rdata_ff[3] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_four    <= mem_rdata_ff[4] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_five    <= mem_rdata_ff[5] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_six     <= mem_rdata_ff[6] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.pixel_seven   <= mem_rdata_ff[7] ? fg_color_ff : bg_color_ff;
         rsp_data_ff.final_row     <= stage_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.is_draw  = (word_class == CLASS_DRAW);
   assign status.run_done = !issuing_ff && !stage_valid_ff;

endmodule
